/* rtl/hsrt_pkg.sv */
// shared types and constants for the heap sorter
package hsrt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic                    is_last;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflow;
    } result_t;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
    } lane_t;

endpackage

/* rtl/hsrt_cell.sv */
// one sorting cell: keeps the smaller value, passes the larger one right
module hsrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  hsrt_pkg::lane_t ins_in,
    output hsrt_pkg::lane_t ins_out,
    input  hsrt_pkg::lane_t right_in,
    output hsrt_pkg::lane_t hold_out
);
    import hsrt_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    carry_valid_reg, carry_valid_next;
    logic signed [VAL_W-1:0] carry_value_reg, carry_value_next;

    always_comb
    begin
        valid_next       = valid_reg;
        value_next       = value_reg;
        carry_valid_next = 1'b0;
        carry_value_next = carry_value_reg;
        if (shift)
        begin
            valid_next = right_in.valid;
            value_next = right_in.value;
        end
        else if (ins_in.valid)
        begin
            if (!valid_reg)
            begin
                valid_next = 1'b1;
                value_next = ins_in.value;
            end
            else if (ins_in.value < value_reg)
            begin
                value_next       = ins_in.value;
                carry_valid_next = 1'b1;
                carry_value_next = value_reg;
            end
            else
            begin
                carry_valid_next = 1'b1;
                carry_value_next = ins_in.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            carry_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            carry_valid_reg <= carry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        carry_value_reg <= carry_value_next;
    end

    assign ins_out.valid  = carry_valid_reg;
    assign ins_out.value  = carry_value_reg;
    assign hold_out.valid = valid_reg;
    assign hold_out.value = value_reg;

endmodule

/* rtl/heap_sorter.sv */
// heap sorter top level: loads a set, sorts it in a cell chain, emits ascending
// phases: load the set of n words, drain the cell chain, then emit the n sorted results
// throughput: one input word per cycle while loading; results one per cycle
// the drain waits for the last insertion to ripple down the cell chain
// busy rises after the closing word is accepted and stays high through the final result; the receiver cannot stall
// reset clears the chain valid bits, the set count and the overflow flag
module heap_sorter #(
    parameter int DEPTH = hsrt_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hsrt_pkg::item_t   item,
    output logic              result_valid,
    output hsrt_pkg::result_t result
);
    import hsrt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   tmr_reg, tmr_next;
    logic            ovf_reg, ovf_next;
    logic            accept;
    logic            shift;
    lane_t           ins_chain  [DEPTH+1];
    lane_t           hold_chain [DEPTH+1];

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;
    assign shift  = (state_reg == ST_EMIT);

    assign ins_chain[0].valid = accept && (cnt_reg < CW'(DEPTH));
    assign ins_chain[0].value = item.item_value;
    assign hold_chain[DEPTH].valid = 1'b0;
    assign hold_chain[DEPTH].value = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            hsrt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .ins_in   (ins_chain[g]),
                .ins_out  (ins_chain[g+1]),
                .right_in (hold_chain[g+1]),
                .hold_out (hold_chain[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tmr_next   = tmr_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (cnt_reg < CW'(DEPTH))
                        cnt_next = cnt_reg + CW'(1);
                    else
                        ovf_next = 1'b1;
                    if (item.is_last)
                    begin
                        state_next = ST_DRAIN;
                        tmr_next   = cnt_next;
                    end
                end
            end
            ST_DRAIN:
            begin
                tmr_next = tmr_reg - CW'(1);
                if (tmr_reg <= CW'(1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg <= CW'(1))
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            tmr_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tmr_reg   <= tmr_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign result_valid        = shift;
    assign result.sorted_value = hold_chain[0].value;
    assign result.last_out     = (cnt_reg == CW'(1));
    assign result.overflow     = ovf_reg;

`ifndef NO_ASSERTIONS
    a_result_from_full_cell: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hold_chain[0].valid)
        else $error("result taken from an empty cell");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cnt_reg == CW'(1)) |=> (state_reg == ST_LOAD))
        else $error("emit phase did not end after the final word");

    a_chain_empty_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_EMIT && state_reg == ST_LOAD) |-> !hold_chain[0].valid)
        else $error("chain not empty after emit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("set count beyond depth");
`endif

endmodule
